// ----- rtl/core/chd_pkg.sv -----
`default_nettype none

package chd_pkg;

	// command codes on the request channel
	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_EXEC = 2'd1;
	localparam logic [1:0] CMD_REG  = 2'd2;

	// response status codes
	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_WAITING      = 3'd1;
	localparam logic [2:0] ST_TOO_LONG     = 3'd2;
	localparam logic [2:0] ST_NO_LINE      = 3'd3;
	localparam logic [2:0] ST_EMPTY        = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND    = 3'd5;
	localparam logic [2:0] ST_WRONG_PARAMS = 3'd6;
	localparam logic [2:0] ST_TABLE_FULL   = 3'd7;

	localparam logic [31:0] HASH_SEED = 32'd5381;

	// character codes
	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam logic [5:0]        SEP_MAX    = 6'd63;
	localparam logic signed [6:0] PARAMS_ANY = -7'sd1;

	typedef enum logic [1:0] {
		OP_CHAR,
		OP_EXEC,
		OP_REG,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		CLS_IGNORE,
		CLS_NEWLINE,
		CLS_SEP,
		CLS_TEXT
	} char_cls_t;

	typedef enum logic [1:0] {
		PH_BEFORE,
		PH_INSIDE,
		PH_AFTER
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WALK,
		BK_DONE
	} bk_state_t;

	// classified word handed from the front end to the back end
	typedef struct packed {
		op_t                op;
		char_cls_t          cls;
		logic [7:0]         ch;
		logic [31:0]        entry_hash;
		logic signed [6:0]  entry_params;
	} cmd_word_t;

endpackage

`default_nettype wire

// ----- rtl/core/chd_if.sv -----
`default_nettype none

interface chd_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic [7:0]        char_code;
	logic [31:0]       entry_hash;
	logic signed [6:0] entry_params;

	modport source (output valid, command, char_code, entry_hash, entry_params, input ready);
	modport sink (input valid, command, char_code, entry_hash, entry_params, output ready);
endinterface

interface chd_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  entry_index;
	logic [5:0]  param_count;
	logic [31:0] name_hash;

	modport source (output valid, status, entry_index, param_count, name_hash, input ready);
	modport sink (input valid, status, entry_index, param_count, name_hash, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/chd_ram.sv -----
`default_nettype none

module chd_ram #(
	parameter int WIDTH = 39,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/chd_front.sv -----
`default_nettype none

module chd_front (
	chd_req_if.sink                req,
	input  wire logic              full,
	output logic                   push,
	output chd_pkg::cmd_word_t     word
);

	// take a word whenever the queue has room
	assign req.ready = !full;
	assign push      = req.valid && !full;

	// decode command and classify the character
	always_comb begin
		word.entry_hash   = req.entry_hash;
		word.entry_params = req.entry_params;

		case (req.command)
			chd_pkg::CMD_ADD:  word.op = chd_pkg::OP_CHAR;
			chd_pkg::CMD_EXEC: word.op = chd_pkg::OP_EXEC;
			chd_pkg::CMD_REG:  word.op = chd_pkg::OP_REG;
			default:           word.op = chd_pkg::OP_NOP;
		endcase

		// fold upper case to lower case
		word.ch = req.char_code;
		if (req.char_code inside {[chd_pkg::CH_UPPER_A:chd_pkg::CH_UPPER_Z]}) begin
			word.ch = req.char_code + chd_pkg::CASE_OFFSET;
		end

		case (req.char_code)
			chd_pkg::CH_NUL, chd_pkg::CH_CR:  word.cls = chd_pkg::CLS_IGNORE;
			chd_pkg::CH_LF:                   word.cls = chd_pkg::CLS_NEWLINE;
			chd_pkg::CH_SPACE, chd_pkg::CH_TAB: word.cls = chd_pkg::CLS_SEP;
			default:                          word.cls = chd_pkg::CLS_TEXT;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/chd_queue.sv -----
`default_nettype none

module chd_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  chd_pkg::cmd_word_t      wdata,
	output logic                    full,
	input  wire logic               pop,
	output logic                    valid,
	output chd_pkg::cmd_word_t      rdata
);

	localparam logic [1:0] QUEUE_DEPTH = 2'd2;

	chd_pkg::cmd_word_t mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;

	assign full  = (cnt_q == QUEUE_DEPTH);
	assign valid = (cnt_q != 2'd0);
	assign rdata = mem_q[rd_ptr_q];

	// store words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/chd_back.sv -----
`default_nettype none

module chd_back #(
	parameter int LINE_MAX    = 64,
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  chd_pkg::cmd_word_t     q_word,
	output logic                   pop,
	chd_rsp_if.source              rsp
);

	localparam int LW      = $clog2(LINE_MAX + 1);
	localparam int UW      = $clog2(TABLE_DEPTH + 1);
	localparam int IW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int ENTRY_W = 39;

	localparam logic [LW-1:0] LINE_LIMIT  = LW'(LINE_MAX);
	localparam logic [UW-1:0] TABLE_LIMIT = UW'(TABLE_DEPTH);

	chd_pkg::bk_state_t state_q, state_d;

	// line state
	logic              line_ready_q, line_ready_d;
	logic              discarding_q, discarding_d;
	logic [LW-1:0]     len_q, len_d;
	logic [31:0]       hash_q, hash_d;
	chd_pkg::phase_t   phase_q, phase_d;
	logic              last_sp_q, last_sp_d;
	logic [5:0]        sep_q, sep_d;
	logic [UW-1:0]     used_q, used_d;

	// table walk
	logic [UW-1:0]     rd_idx_q, rd_idx_d;
	logic              cmp_vld_q, cmp_vld_d;
	logic [UW-1:0]     cmp_idx_q, cmp_idx_d;
	logic [UW-1:0]     cmp_next;
	logic [2:0]        res_status_q, res_status_d;
	logic [UW-1:0]     res_idx_q, res_idx_d;

	// output register
	logic              rsp_vld_q;
	logic [2:0]        rsp_status_q;
	logic [3:0]        rsp_index_q;
	logic [5:0]        rsp_count_q;
	logic [31:0]       rsp_hash_q;

	logic              out_free;
	logic              exec_walk;
	logic              clear;
	logic              load;
	logic [2:0]        ld_status;
	logic [UW-1:0]     ld_index;
	logic [UW+3:0]     ld_index_ext;
	logic [5:0]        ld_count;
	logic [31:0]       ld_hash;
	logic [31:0]       ch_ext;

	logic                   ram_we;
	logic [ENTRY_W-1:0]     ram_rdata;
	logic [31:0]            ram_hash;
	logic signed [6:0]      ram_params;
	logic                   hit;
	logic                   last_cmp;
	logic                   walk_end;
	logic                   params_ok;

	chd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (used_q[IW-1:0]),
		.wdata ({q_word.entry_hash, q_word.entry_params}),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	assign ram_hash   = ram_rdata[ENTRY_W-1:7];
	assign ram_params = ram_rdata[6:0];

	assign out_free = !rsp_vld_q || rsp.ready;
	assign pop      = (state_q == chd_pkg::BK_IDLE) && q_valid && out_free;
	assign exec_walk = line_ready_q && (len_q != '0) && (used_q != '0);

	// compare stage of the table walk
	assign cmp_next  = cmp_idx_q + 1'b1;
	assign hit       = (ram_hash == hash_q);
	assign last_cmp  = (cmp_next == used_q);
	assign walk_end  = cmp_vld_q && (hit || last_cmp);
	assign params_ok = (ram_params == chd_pkg::PARAMS_ANY)
		|| (!ram_params[6] && (ram_params[5:0] == sep_q));

	assign ch_ext = {{24{q_word.ch[7]}}, q_word.ch};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			chd_pkg::BK_IDLE: begin
				if (pop && (q_word.op == chd_pkg::OP_EXEC) && exec_walk) begin
					state_d = chd_pkg::BK_WALK;
				end
			end
			chd_pkg::BK_WALK: begin
				if (walk_end) begin
					state_d = chd_pkg::BK_DONE;
				end
			end
			chd_pkg::BK_DONE: begin
				if (out_free) begin
					state_d = chd_pkg::BK_IDLE;
				end
			end
			default: state_d = chd_pkg::BK_IDLE;
		endcase
	end

	// datapath updates and result formation
	always_comb begin
		line_ready_d = line_ready_q;
		discarding_d = discarding_q;
		len_d        = len_q;
		hash_d       = hash_q;
		phase_d      = phase_q;
		last_sp_d    = last_sp_q;
		sep_d        = sep_q;
		used_d       = used_q;
		rd_idx_d     = rd_idx_q;
		cmp_vld_d    = cmp_vld_q;
		cmp_idx_d    = cmp_idx_q;
		res_status_d = res_status_q;
		res_idx_d    = res_idx_q;
		ram_we       = 1'b0;
		clear        = 1'b0;
		load         = 1'b0;
		ld_status    = chd_pkg::ST_OK;
		ld_index     = '0;
		ld_count     = '0;
		ld_hash      = '0;

		case (state_q)
			chd_pkg::BK_IDLE: begin
				if (pop) begin
					load = 1'b1;
					case (q_word.op)
						chd_pkg::OP_CHAR: begin
							if (line_ready_q) begin
								ld_status = chd_pkg::ST_WAITING;
							end else begin
								case (q_word.cls)
									chd_pkg::CLS_IGNORE: begin
									end
									chd_pkg::CLS_NEWLINE: begin
										if (discarding_q) begin
											clear     = 1'b1;
											ld_status = chd_pkg::ST_TOO_LONG;
										end else begin
											line_ready_d = 1'b1;
										end
									end
									default: begin
										if (discarding_q || (len_q >= LINE_LIMIT)) begin
											// drop the rest of an overlong line
											discarding_d = 1'b1;
											ld_status    = chd_pkg::ST_TOO_LONG;
										end else begin
											len_d = len_q + 1'b1;
											if (q_word.cls == chd_pkg::CLS_SEP) begin
												if ((len_q != '0) && !last_sp_q
													&& (sep_q != chd_pkg::SEP_MAX)) begin
													sep_d = sep_q + 1'b1;
												end
												if (phase_q == chd_pkg::PH_INSIDE) begin
													phase_d = chd_pkg::PH_AFTER;
												end
												last_sp_d = 1'b1;
											end else begin
												// hash = hash * 33 + c on the first token
												if (phase_q != chd_pkg::PH_AFTER) begin
													hash_d  = (hash_q << 5) + hash_q + ch_ext;
													phase_d = chd_pkg::PH_INSIDE;
												end
												last_sp_d = 1'b0;
											end
										end
									end
								endcase
							end
						end
						chd_pkg::OP_EXEC: begin
							if (!line_ready_q) begin
								ld_status = chd_pkg::ST_NO_LINE;
							end else if (len_q == '0) begin
								ld_status = chd_pkg::ST_EMPTY;
								ld_count  = sep_q;
								ld_hash   = hash_q;
								clear     = 1'b1;
							end else if (used_q == '0) begin
								ld_status = chd_pkg::ST_NOT_FOUND;
								ld_count  = sep_q;
								ld_hash   = hash_q;
								clear     = 1'b1;
							end else begin
								// start the table walk at entry zero
								load      = 1'b0;
								rd_idx_d  = '0;
								cmp_vld_d = 1'b0;
							end
						end
						chd_pkg::OP_REG: begin
							if (used_q >= TABLE_LIMIT) begin
								ld_status = chd_pkg::ST_TABLE_FULL;
							end else begin
								ram_we   = 1'b1;
								ld_index = used_q;
								used_d   = used_q + 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			chd_pkg::BK_WALK: begin
				// issue the next read while comparing the previous entry
				cmp_vld_d = (rd_idx_q < used_q);
				cmp_idx_d = rd_idx_q;
				rd_idx_d  = rd_idx_q + 1'b1;
				if (cmp_vld_q) begin
					if (hit) begin
						res_idx_d    = cmp_idx_q;
						res_status_d = params_ok ? chd_pkg::ST_OK : chd_pkg::ST_WRONG_PARAMS;
					end else if (last_cmp) begin
						res_idx_d    = '0;
						res_status_d = chd_pkg::ST_NOT_FOUND;
					end
				end
			end
			chd_pkg::BK_DONE: begin
				if (out_free) begin
					load      = 1'b1;
					ld_status = res_status_q;
					ld_index  = res_idx_q;
					ld_count  = sep_q;
					ld_hash   = hash_q;
					clear     = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (clear) begin
			line_ready_d = 1'b0;
			discarding_d = 1'b0;
			len_d        = '0;
			hash_d       = chd_pkg::HASH_SEED;
			phase_d      = chd_pkg::PH_BEFORE;
			last_sp_d    = 1'b0;
			sep_d        = '0;
		end
	end

	assign ld_index_ext = {4'b0000, ld_index};

	// control and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= chd_pkg::BK_IDLE;
			line_ready_q <= 1'b0;
			discarding_q <= 1'b0;
			len_q        <= '0;
			hash_q       <= chd_pkg::HASH_SEED;
			phase_q      <= chd_pkg::PH_BEFORE;
			last_sp_q    <= 1'b0;
			sep_q        <= '0;
			used_q       <= '0;
			rd_idx_q     <= '0;
			cmp_vld_q    <= 1'b0;
			rsp_vld_q    <= 1'b0;
		end else begin
			state_q      <= state_d;
			line_ready_q <= line_ready_d;
			discarding_q <= discarding_d;
			len_q        <= len_d;
			hash_q       <= hash_d;
			phase_q      <= phase_d;
			last_sp_q    <= last_sp_d;
			sep_q        <= sep_d;
			used_q       <= used_d;
			rd_idx_q     <= rd_idx_d;
			cmp_vld_q    <= cmp_vld_d;
			if (load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// walk results and output payload
	always_ff @(posedge clk) begin
		cmp_idx_q    <= cmp_idx_d;
		res_status_q <= res_status_d;
		res_idx_q    <= res_idx_d;
		if (load) begin
			rsp_status_q <= ld_status;
			rsp_index_q  <= ld_index_ext[3:0];
			rsp_count_q  <= ld_count;
			rsp_hash_q   <= ld_hash;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.entry_index = rsp_index_q;
	assign rsp.param_count = rsp_count_q;
	assign rsp.name_hash   = rsp_hash_q;

endmodule

`default_nettype wire

// ----- rtl/core/command_line_hash_dispatcher_unit.sv -----
// A two-word input queue decouples input; each word passes it, then the output register.
// Execute with a match search walks the table from entry zero to a hit or the last entry;
// the table has one write port and a registered read port, read one entry per cycle.
// Throughput: one character or register word per cycle unless a walk or rsp stall holds.
// Reset: arst_n clears the line, the table fill count and all handshake state at once.
`default_nettype none

module command_line_hash_dispatcher_unit #(
	parameter int LINE_MAX    = 64,
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	chd_req_if.sink    req,
	chd_rsp_if.source  rsp
);

	chd_pkg::cmd_word_t fe_word;
	chd_pkg::cmd_word_t q_word;
	logic               fe_push;
	logic               q_full;
	logic               q_valid;
	logic               be_pop;

	chd_front u_front (
		.req  (req),
		.full (q_full),
		.push (fe_push),
		.word (fe_word)
	);

	chd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_push),
		.wdata  (fe_word),
		.full   (q_full),
		.pop    (be_pop),
		.valid  (q_valid),
		.rdata  (q_word)
	);

	chd_back #(
		.LINE_MAX    (LINE_MAX),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_word  (q_word),
		.pop     (be_pop),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire

// ----- rtl/core/chd_checker.sv -----
`default_nettype none

module chd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [2:0]  rsp_status,
	input wire logic [3:0]  rsp_entry_index,
	input wire logic [5:0]  rsp_param_count,
	input wire logic [31:0] rsp_name_hash
);

	logic [2:0] pend_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// count words accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			case ({req_acc, rsp_acc})
				2'b10:   pend_q <= pend_q + 3'd1;
				2'b01:   pend_q <= pend_q - 3'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid
			&& $stable({rsp_status, rsp_entry_index, rsp_param_count, rsp_name_hash}))
		else $error("response changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_acc |-> pend_q != 3'd0)
		else $error("response without an outstanding request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("more words in flight than the block can hold");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == chd_pkg::ST_WAITING || rsp_status == chd_pkg::ST_TOO_LONG
			|| rsp_status == chd_pkg::ST_NO_LINE || rsp_status == chd_pkg::ST_TABLE_FULL)
		|-> rsp_entry_index == 4'd0 && rsp_param_count == 6'd0 && rsp_name_hash == 32'd0)
		else $error("line fields set on a non-execute status");

endmodule

bind command_line_hash_dispatcher_unit chd_checker u_chd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_entry_index (rsp.entry_index),
	.rsp_param_count (rsp.param_count),
	.rsp_name_hash   (rsp.name_hash)
);

`default_nettype wire
